[rtl/rcw_pkg.sv]
// Package with the constants, types and helper functions of the Reno congestion window.
`timescale 1ns / 1ps
package rcw_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_W = 32;
  localparam int INIT_THRESH_W = 16;
  localparam int PHASE_W = 2;
  localparam int DUP_W = 4;
  localparam int CFG_IDX_W = 1;

  localparam int DIVISOR_W = WORD_W - FRAC_BITS;
  localparam int REM_W = DIVISOR_W + 1;
  localparam int QUO_W = FRAC_BITS + 1;
  localparam int DIV_CNT_W = $clog2(FRAC_BITS + 1);

  localparam logic [WORD_W-1:0] FX_ONE = WORD_W'(1) << FRAC_BITS;
  localparam logic [WORD_W-1:0] WORD_MAX = '1;

  localparam logic [PHASE_W-1:0] PH_SLOW = 2'd0;
  localparam logic [PHASE_W-1:0] PH_AVOID = 2'd1;
  localparam logic [PHASE_W-1:0] PH_RECOVER = 2'd2;

  localparam logic [DUP_W-1:0] DUP_ENTER = 4'd3;
  localparam logic [DUP_W-1:0] DUP_MAX = 4'd15;

  localparam logic CMD_ACK = 1'b0;
  localparam logic CMD_TIMEOUT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_INIT_THRESH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FINAL_BASE = 1'b1;

  localparam logic [INIT_THRESH_W-1:0] INIT_THRESH_RST = 16'd30;
  localparam logic [WORD_W-1:0] FINAL_BASE_RST = 32'd2;
  localparam logic [WORD_W-1:0] BASE_RST = 32'd1;
  localparam logic [INIT_THRESH_W-1:0] RECOVER_INFLATE = 16'd3;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_OUT  = 3'b100
  } state_t;

  function automatic logic [WORD_W-1:0] sat_add(input logic [WORD_W-1:0] a,
                                                input logic [WORD_W-1:0] b);
    logic [WORD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WORD_W] ? WORD_MAX : s[WORD_W-1:0];
  endfunction

  function automatic logic [WORD_W-1:0] whole_to_fixed(input logic [INIT_THRESH_W-1:0] segs);
    logic [WORD_W+INIT_THRESH_W-1:0] v;
    v = {{WORD_W{1'b0}}, segs} << FRAC_BITS;
    return (v[WORD_W+INIT_THRESH_W-1:WORD_W] != '0) ? WORD_MAX : v[WORD_W-1:0];
  endfunction

endpackage

[rtl/rcw_in_if.sv]
// Input channel carrying acknowledgment and timeout events.
`timescale 1ns / 1ps
interface rcw_in_if import rcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [WORD_W-1:0] ack_number;
  logic              ack_flag_set;

  modport source(output valid, cmd, ack_number, ack_flag_set, input ready);
  modport sink(input valid, cmd, ack_number, ack_flag_set, output ready);
endinterface

[rtl/rcw_out_if.sv]
// Result channel carrying the congestion state after each event.
`timescale 1ns / 1ps
interface rcw_out_if import rcw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [WORD_W-1:0]  window_size;
  logic [WORD_W-1:0]  slow_start_threshold;
  logic [PHASE_W-1:0] phase;
  logic               retransmit;
  logic [WORD_W-1:0]  window_base;
  logic               transfer_done;
  logic [DUP_W-1:0]   duplicate_count;

  modport source(output valid, window_size, slow_start_threshold, phase, retransmit,
                 window_base, transfer_done, duplicate_count, input ready);
  modport sink(input valid, window_size, slow_start_threshold, phase, retransmit,
               window_base, transfer_done, duplicate_count, output ready);
endinterface

[rtl/reno_congestion_window.sv]
// Reno-style sender congestion window with an iterative reciprocal divider.
//
// Each input transfer is an acknowledgment or a timeout and yields exactly one
// result transfer with the updated window, threshold, phase, base, duplicate count,
// done flag and a retransmit pulse. Window and threshold are unsigned fixed point with
// FRAC_BITS fraction bits. Most events pass from the input transfer through ST_OUT to the
// result register. A new acknowledgment in congestion avoidance first passes through
// ST_DIV, the serial restoring divider that forms one over the whole-segment window one
// quotient bit per cycle, before it reaches ST_OUT. The input is not ready
// while an event is in progress; a finished result waits in the output register while
// the next event is taken. Configuration writes are meant for idle periods only.
`timescale 1ns / 1ps
module reno_congestion_window import rcw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  rcw_in_if.sink               in_ch,
  rcw_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data
);

  state_t                  state_r, state_nxt;
  logic [WORD_W-1:0]       final_base_r, final_base_nxt;
  logic [WORD_W-1:0]       cwnd_r, cwnd_nxt;
  logic [WORD_W-1:0]       thresh_r, thresh_nxt;
  logic [PHASE_W-1:0]      phase_r, phase_nxt;
  logic [DUP_W-1:0]        dup_r, dup_nxt;
  logic [WORD_W-1:0]       base_r, base_nxt;
  logic                    done_r, done_nxt;
  logic                    rexmit_r, rexmit_nxt;
  logic [DIV_CNT_W-1:0]    div_cnt_r, div_cnt_nxt;
  logic [REM_W-1:0]        rem_r, rem_nxt;
  logic [QUO_W-1:0]        quo_r, quo_nxt;
  logic [DIVISOR_W-1:0]    divisor_r, divisor_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]       out_cwnd_r, out_thresh_r, out_base_r;
  logic [PHASE_W-1:0]      out_phase_r;
  logic                    out_rexmit_r, out_done_r;
  logic [DUP_W-1:0]        out_dup_r;

  logic                    accept;
  logic                    load_out;
  logic                    new_ack;
  logic [DUP_W-1:0]        dup_inc;
  logic [WORD_W-1:0]       base_after;
  logic [DIVISOR_W-1:0]    whole;
  logic [REM_W-1:0]        rem_sh;
  logic                    div_ge;
  logic [QUO_W-1:0]        quo_fin;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept = in_ch.valid && in_ch.ready;
  assign load_out = (state_r == ST_OUT) && (!out_valid_r || out_ch.ready);

  assign new_ack = in_ch.ack_flag_set && (in_ch.ack_number >= base_r);
  assign dup_inc = (dup_r != DUP_MAX) ? dup_r + 4'd1 : dup_r;
  assign base_after = new_ack ? in_ch.ack_number + 32'd1 : base_r;
  assign whole = cwnd_r[WORD_W-1:FRAC_BITS];

  assign rem_sh = {rem_r[REM_W-2:0], (div_cnt_r == DIV_CNT_W'(FRAC_BITS))};
  assign div_ge = rem_sh >= {1'b0, divisor_r};
  assign quo_fin = {quo_r[QUO_W-2:0], div_ge};

  always_comb begin
    state_nxt = state_r;
    final_base_nxt = final_base_r;
    cwnd_nxt = cwnd_r;
    thresh_nxt = thresh_r;
    phase_nxt = phase_r;
    dup_nxt = dup_r;
    base_nxt = base_r;
    done_nxt = done_r;
    rexmit_nxt = rexmit_r;
    div_cnt_nxt = div_cnt_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    divisor_nxt = divisor_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_OUT;
          rexmit_nxt = 1'b0;
          if (in_ch.cmd == CMD_TIMEOUT) begin
            thresh_nxt = cwnd_r >> 1;
            cwnd_nxt = FX_ONE;
            phase_nxt = PH_SLOW;
            dup_nxt = '0;
            rexmit_nxt = 1'b1;
          end else begin
            if (new_ack) begin
              dup_nxt = '0;
              priority case (phase_r)
                PH_SLOW: begin
                  cwnd_nxt = sat_add(cwnd_r, FX_ONE);
                  if (sat_add(cwnd_r, FX_ONE) > thresh_r) begin
                    phase_nxt = PH_AVOID;
                  end
                end
                PH_AVOID: begin
                  state_nxt = ST_DIV;
                  divisor_nxt = (whole == '0) ? DIVISOR_W'(1) : whole;
                  div_cnt_nxt = DIV_CNT_W'(FRAC_BITS);
                  rem_nxt = '0;
                  quo_nxt = '0;
                end
                default: begin
                  phase_nxt = PH_AVOID;
                  cwnd_nxt = thresh_r;
                end
              endcase
            end else begin
              dup_nxt = dup_inc;
              if (phase_r != PH_RECOVER && dup_inc == DUP_ENTER) begin
                phase_nxt = PH_RECOVER;
                thresh_nxt = cwnd_r >> 1;
                cwnd_nxt = sat_add(cwnd_r >> 1, whole_to_fixed(RECOVER_INFLATE));
                rexmit_nxt = 1'b1;
              end else if (phase_r == PH_RECOVER) begin
                cwnd_nxt = sat_add(cwnd_r, FX_ONE);
              end
            end
            base_nxt = base_after;
            if (base_after == final_base_r) begin
              done_nxt = 1'b1;
            end
          end
        end
      end
      ST_DIV: begin
        rem_nxt = div_ge ? rem_sh - {1'b0, divisor_r} : rem_sh;
        quo_nxt = quo_fin;
        div_cnt_nxt = div_cnt_r - DIV_CNT_W'(1);
        if (div_cnt_r == '0) begin
          cwnd_nxt = sat_add(cwnd_r, {{(WORD_W-QUO_W){1'b0}}, quo_fin});
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_INIT_THRESH: begin
          thresh_nxt = whole_to_fixed(cfg_data[INIT_THRESH_W-1:0]);
        end
        CFG_FINAL_BASE: begin
          final_base_nxt = cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      final_base_r <= FINAL_BASE_RST;
      cwnd_r <= FX_ONE;
      thresh_r <= whole_to_fixed(INIT_THRESH_RST);
      phase_r <= PH_SLOW;
      dup_r <= '0;
      base_r <= BASE_RST;
      done_r <= 1'b0;
      rexmit_r <= 1'b0;
      div_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      final_base_r <= final_base_nxt;
      cwnd_r <= cwnd_nxt;
      thresh_r <= thresh_nxt;
      phase_r <= phase_nxt;
      dup_r <= dup_nxt;
      base_r <= base_nxt;
      done_r <= done_nxt;
      rexmit_r <= rexmit_nxt;
      div_cnt_r <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    divisor_r <= divisor_nxt;
    if (load_out) begin
      out_cwnd_r <= cwnd_r;
      out_thresh_r <= thresh_r;
      out_phase_r <= phase_r;
      out_rexmit_r <= rexmit_r;
      out_base_r <= base_r;
      out_done_r <= done_r;
      out_dup_r <= dup_r;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.window_size = out_cwnd_r;
  assign out_ch.slow_start_threshold = out_thresh_r;
  assign out_ch.phase = out_phase_r;
  assign out_ch.retransmit = out_rexmit_r;
  assign out_ch.window_base = out_base_r;
  assign out_ch.transfer_done = out_done_r;
  assign out_ch.duplicate_count = out_dup_r;

endmodule

[rtl/rcw_checker.sv]
// Port-level assertions for the Reno congestion window and their bind statement.
`timescale 1ns / 1ps
module rcw_checker import rcw_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [WORD_W-1:0]  window_size,
  input logic [PHASE_W-1:0] phase,
  input logic               retransmit,
  input logic [DUP_W-1:0]   duplicate_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(window_size) && $stable(phase))
    else $error("Result changed while stalled.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("Input stayed ready after a transfer.");

  a_timeout_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && retransmit && phase == PH_SLOW |-> window_size == FX_ONE)
    else $error("Timeout result does not reset the window to one segment.");

  a_recover_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && retransmit && phase == PH_RECOVER |-> duplicate_count == DUP_ENTER)
    else $error("Fast recovery entered without the third duplicate.");

endmodule

bind reno_congestion_window rcw_checker u_rcw_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .window_size     (out_ch.window_size),
  .phase           (out_ch.phase),
  .retransmit      (out_ch.retransmit),
  .duplicate_count (out_ch.duplicate_count)
);
